FILE: rtl/core/pwmu_pkg.sv
package pwmu_pkg;

	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
	localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
	localparam int unsigned WORD_W    = $clog2(MEM_WORDS);

	// Byte count as a 33-bit value so that physical addresses past 32 bits compare correctly.
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	localparam logic [1:0] OP_VREAD  = 2'd0;
	localparam logic [1:0] OP_VWRITE = 2'd1;
	localparam logic [1:0] OP_PREAD  = 2'd2;
	localparam logic [1:0] OP_PWRITE = 2'd3;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_NP    = 2'd1;
	localparam logic [1:0] FAULT_RANGE = 2'd2;

	localparam logic CFG_PAGING = 1'b0;
	localparam logic CFG_PDBASE = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] address;
		logic [2:0]  length;
		logic [31:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  fault;
	} result_t;

	// One access to the word-wide memory: a full-word read or a single-byte write.
	typedef struct packed {
		logic              re;
		logic              we;
		logic [WORD_W-1:0] addr;
		logic [1:0]        lane;
		logic [7:0]        wbyte;
	} mem_req_t;

	function automatic logic [31:0] dir_ea(input logic [31:0] base, input logic [31:0] va);
		return {base[31:12], va[31:22], 2'b00};
	endfunction

	function automatic logic [31:0] tbl_ea(input logic [31:0] pde, input logic [31:0] va);
		return {pde[31:12], va[21:12], 2'b00};
	endfunction

	function automatic logic in_range(input logic [31:0] ea);
		return {1'b0, ea} < MEM_LIMIT;
	endfunction

endpackage

FILE: rtl/core/pwmu_mem.sv
module pwmu_mem (
	input  logic                  clk,
	input  pwmu_pkg::mem_req_t    req,
	output logic [3:0][7:0]       rdata
);

	logic [3:0][7:0] mem [pwmu_pkg::MEM_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr][req.lane] <= req.wbyte;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

FILE: rtl/core/two_level_page_walk_memory_unit.sv
// A physical access goes straight to the range check and byte transfer; a translated one
// first walks directory and table, twice when it crosses a page. Faults finish earlier.
// Each walk step is one read of the single memory port, and the data moves one byte per
// cycle through that same port. One access at a time: busy stays high until the done
// cycle (it never rises for an out-of-range directory address); results cannot be stalled.
// Reset clears the control state and both registers; memory contents are undefined.
module two_level_page_walk_memory_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pwmu_pkg::cmd_t    cmd,
	output logic              done,
	output pwmu_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PDE,
		S_PTE,
		S_CHECK,
		S_XFER,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic              paging_q;
	logic [31:0]       pdb_q;
	logic              write_q;
	logic [31:0]       addr_q;
	logic [31:0]       va2_q;
	logic [2:0]        len_q;
	logic [2:0]        n1_q;
	logic              need2_q;
	logic              part_q;
	logic [3:0][7:0]   wdata_q;
	logic [32:0]       p1_q;
	logic [32:0]       p2_q;
	logic [1:0]        idx_q;
	logic [3:0][7:0]   rd_q;
	logic              rd_pend_q;
	logic [1:0]        rd_idx_q;
	logic [1:0]        rd_lane_q;
	logic              done_q;
	pwmu_pkg::result_t result_q;

	pwmu_pkg::mem_req_t mem_req;
	logic [3:0][7:0]    mem_rdata;

	pwmu_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	// Command decode at the start beat.
	logic        in_virt;
	logic        in_walk;
	logic [2:0]  in_len;
	logic [12:0] in_rem;
	logic [2:0]  in_n1;
	logic [31:0] in_dir_ea;

	always_comb begin
		in_virt = (cmd.opcode == pwmu_pkg::OP_VREAD) || (cmd.opcode == pwmu_pkg::OP_VWRITE);
		in_walk = in_virt && paging_q;
		priority if (cmd.length == 3'd0) begin
			in_len = 3'd1;
		end else if (cmd.length > 3'd4) begin
			in_len = 3'd4;
		end else begin
			in_len = cmd.length;
		end
		in_rem = 13'h1000 - {1'b0, cmd.address[11:0]};
		if (!in_virt || (in_rem > 13'(in_len))) begin
			in_n1 = in_len;
		end else begin
			in_n1 = in_rem[2:0];
		end
		in_dir_ea = pwmu_pkg::dir_ea(pdb_q, cmd.address);
	end

	// Walk and transfer datapath.
	logic [31:0]       va_cur;
	logic [31:0]       entry;
	logic [31:0]       tea;
	logic [31:0]       dir2_ea;
	logic [32:0]       walk_pa;
	logic [2:0]        len2;
	logic [32:0]       last1;
	logic [32:0]       last2;
	logic              range_bad;
	logic              sel1;
	logic [1:0]        boff;
	logic [32:0]       bbase;
	logic [pwmu_pkg::ADDR_W-1:0] baddr;
	logic              last_byte;
	logic [3:0][7:0]   rd_final;

	always_comb begin
		va_cur    = part_q ? va2_q : addr_q;
		entry     = mem_rdata;
		tea       = pwmu_pkg::tbl_ea(entry, va_cur);
		dir2_ea   = pwmu_pkg::dir_ea(pdb_q, va2_q);
		walk_pa   = {1'b0, entry[31:12], va_cur[11:0]};
		len2      = len_q - n1_q;
		last1     = p1_q + 33'(n1_q) - 33'd1;
		last2     = p2_q + 33'(len2) - 33'd1;
		range_bad = (last1 >= pwmu_pkg::MEM_LIMIT)
			|| (need2_q && (last2 >= pwmu_pkg::MEM_LIMIT));
		sel1      = ({1'b0, idx_q} < n1_q);
		boff      = sel1 ? idx_q : 2'(idx_q - n1_q[1:0]);
		bbase     = sel1 ? p1_q : p2_q;
		baddr     = bbase[pwmu_pkg::ADDR_W-1:0] + pwmu_pkg::ADDR_W'(boff);
		last_byte = ({1'b0, idx_q} == (len_q - 3'd1));
		rd_final  = rd_q;
		if (rd_pend_q) begin
			rd_final[rd_idx_q] = mem_rdata[rd_lane_q];
		end
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_req.addr = in_dir_ea[pwmu_pkg::ADDR_W-1:2];
				mem_req.re   = start && in_walk && pwmu_pkg::in_range(in_dir_ea);
			end
			S_PDE: begin
				mem_req.addr = tea[pwmu_pkg::ADDR_W-1:2];
				mem_req.re   = entry[0] && pwmu_pkg::in_range(tea);
			end
			S_PTE: begin
				mem_req.addr = dir2_ea[pwmu_pkg::ADDR_W-1:2];
				mem_req.re   = !part_q && need2_q && entry[0]
					&& pwmu_pkg::in_range(dir2_ea);
			end
			S_XFER: begin
				mem_req.addr  = baddr[pwmu_pkg::ADDR_W-1:2];
				mem_req.lane  = baddr[1:0];
				mem_req.wbyte = wdata_q[idx_q];
				mem_req.re    = !write_q;
				mem_req.we    = write_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			pdb_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pwmu_pkg::CFG_PAGING: paging_q <= cfg_data[0];
				pwmu_pkg::CFG_PDBASE: pdb_q    <= cfg_data;
				default:              pdb_q    <= pdb_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			rd_pend_q <= 1'b0;
			result_q  <= '0;
			part_q    <= 1'b0;
			idx_q     <= '0;
			write_q   <= 1'b0;
			addr_q    <= '0;
			va2_q     <= '0;
			len_q     <= '0;
			n1_q      <= '0;
			need2_q   <= 1'b0;
			wdata_q   <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
			rd_q      <= '0;
			rd_idx_q  <= '0;
			rd_lane_q <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_pend_q <= 1'b0;
			if (rd_pend_q) begin
				rd_q[rd_idx_q] <= mem_rdata[rd_lane_q];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						write_q <= cmd.opcode[0];
						addr_q  <= cmd.address;
						va2_q   <= cmd.address + 32'(in_n1);
						len_q   <= in_len;
						n1_q    <= in_n1;
						need2_q <= in_virt && (in_n1 < in_len);
						wdata_q <= cmd.write_data;
						p1_q    <= {1'b0, cmd.address};
						p2_q    <= {1'b0, cmd.address + 32'(in_n1)};
						part_q  <= 1'b0;
						idx_q   <= '0;
						rd_q    <= '0;
						if (!in_walk) begin
							state_q <= S_CHECK;
						end else if (pwmu_pkg::in_range(in_dir_ea)) begin
							state_q <= S_PDE;
						end else begin
							done_q   <= 1'b1;
							result_q <= '{read_data: '0, fault: pwmu_pkg::FAULT_RANGE};
						end
					end
				end
				S_PDE: begin
					priority if (!entry[0]) begin
						done_q   <= 1'b1;
						result_q <= '{read_data: '0, fault: pwmu_pkg::FAULT_NP};
						state_q  <= S_IDLE;
					end else if (!pwmu_pkg::in_range(tea)) begin
						done_q   <= 1'b1;
						result_q <= '{read_data: '0, fault: pwmu_pkg::FAULT_RANGE};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_PTE;
					end
				end
				S_PTE: begin
					if (part_q) begin
						p2_q <= walk_pa;
					end else begin
						p1_q <= walk_pa;
					end
					priority if (!entry[0]) begin
						done_q   <= 1'b1;
						result_q <= '{read_data: '0, fault: pwmu_pkg::FAULT_NP};
						state_q  <= S_IDLE;
					end else if (part_q || !need2_q) begin
						state_q <= S_CHECK;
					end else if (!pwmu_pkg::in_range(dir2_ea)) begin
						done_q   <= 1'b1;
						result_q <= '{read_data: '0, fault: pwmu_pkg::FAULT_RANGE};
						state_q  <= S_IDLE;
					end else begin
						part_q  <= 1'b1;
						state_q <= S_PDE;
					end
				end
				S_CHECK: begin
					// All byte addresses are known here, so a faulting write touches nothing.
					if (range_bad) begin
						done_q   <= 1'b1;
						result_q <= '{read_data: '0, fault: pwmu_pkg::FAULT_RANGE};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_XFER;
					end
				end
				S_XFER: begin
					rd_pend_q <= !write_q;
					rd_idx_q  <= idx_q;
					rd_lane_q <= baddr[1:0];
					idx_q     <= idx_q + 2'd1;
					if (last_byte) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					done_q   <= 1'b1;
					result_q <= '{read_data: write_q ? 32'd0 : 32'(rd_final),
						fault: pwmu_pkg::FAULT_NONE};
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != S_IDLE) || $past(start))
		else $error("result strobe without an access in flight");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE)
		else $error("result strobe while the unit is still busy");

	a_write_only_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> state_q == S_XFER && write_q)
		else $error("memory write outside the data transfer of a write");

	a_pend_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !write_q && (state_q == S_XFER || state_q == S_FINISH))
		else $error("read capture pending outside a read transfer");

endmodule
